[hdl/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define CPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Check a property at every rising edge, reset included.
`define CPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`else

`define CPS_ASSERT(lbl, clk, rst_n, prop)
`define CPS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hdl/cps_pkg.sv]
package cps_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_END,
        MODE_MID
    } t_mode;

endpackage

[hdl/cps_mdiv_step.sv]
module cps_mdiv_step import cps_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_bit,
    input  logic [2*W:0]   i_dot,
    input  logic [2*W:0]   i_len2,
    input  logic [2*W:0]   i_rem,
    input  logic [W-1:0]   i_quo,
    output logic [2*W:0]   o_rem,
    output logic [W-1:0]   o_quo
);

    localparam int AW = 2*W + 3;

    logic [AW-1:0]  w_acc;
    logic [AW-1:0]  w_len1;
    logic [AW-1:0]  w_len2x2;
    logic [AW-1:0]  w_sub;
    logic [1:0]     w_digit;
    logic [2*W:0]   n_rem;
    logic [W-1:0]   n_quo;
    logic [2*W:0]   r_rem;
    logic [W-1:0]   r_quo;

    always_comb begin
        w_acc    = AW'({i_rem, 1'b0}) + (i_bit ? AW'(i_dot) : AW'(0));
        w_len1   = AW'(i_len2);
        w_len2x2 = AW'({i_len2, 1'b0});
        if (w_acc >= w_len2x2) begin
            w_digit = 2'd2;
            w_sub   = w_len2x2;
        end else if (w_acc >= w_len1) begin
            w_digit = 2'd1;
            w_sub   = w_len1;
        end else begin
            w_digit = 2'd0;
            w_sub   = '0;
        end
        n_rem = (2*W+1)'(w_acc - w_sub);
        n_quo = W'({i_quo, 1'b0} + (W+1)'(w_digit));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

[hdl/closest_point_on_segment.sv]
// Nearest point on a 2D segment to a probe point, signed fixed point.
// Input stream: one transfer carries a segment and a probe point; tdata holds
// start_x, start_y, end_x, end_y, probe_x, probe_y from the lowest bit up.
// Output stream: one transfer per input, tdata holds nearest_x, nearest_y.
// Throughput: one item per cycle while the receiver keeps i_m_axis_tready high.
// The pipeline: a divider with one quotient bit per stage over COORD_WIDTH
// stages, behind three stages for differences, products and sums, and one
// output stage for rounding and the final select.
// A zero-length segment or a probe behind the start gives start; a probe
// past the end gives end.
// Reset empties every stage; o_s_axis_tready is high once reset is released.
// When the receiver stalls the output holds, the pipeline keeps accepting
// until every stage is full, then o_s_axis_tready drops; nothing is lost.
module closest_point_on_segment import cps_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // start_x, start_y, end_x, end_y, probe_x, probe_y
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // nearest_x, nearest_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata
);

`include "assert_macros.svh"

    localparam int W     = COORD_WIDTH;
    localparam int NS    = W + 4;
    localparam int DS    = 3;
    localparam int OUT_W = ((2*W+7)/8)*8;
    localparam logic signed [W+1:0] SAT_HI = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO = {3'b111, {(W-1){1'b0}}};

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_go;
    logic          w_in_xfer;
    logic          w_out_xfer;
    logic          w_grow;
    int            w_fill;
    logic          w_div_mid;
    logic          w_out_mid;
    logic          w_quo_ok;

    logic signed [W-1:0] w_sx, w_sy, w_ex, w_ey, w_px, w_py;

    logic signed [W-1:0] r0_sx, r0_sy, r0_ex, r0_ey;
    logic signed [W:0]   r0_dx, r0_dy, r0_qx, r0_qy;

    logic signed [W-1:0]   r1_sx, r1_sy, r1_ex, r1_ey;
    logic signed [W:0]     r1_dx, r1_dy;
    logic signed [2*W+1:0] r1_pxx, r1_pyy, r1_lxx, r1_lyy;

    logic signed [2*W+2:0] w_dot, w_len;
    t_mode                 w_mode;

    t_mode               r_mode [2:NS-2];
    logic [2*W:0]        r_dot  [2:NS-2];
    logic [2*W:0]        r_len2 [2:NS-2];
    logic [W-1:0]        r_magx [2:NS-2];
    logic [W-1:0]        r_magy [2:NS-2];
    logic                r_negx [2:NS-2];
    logic                r_negy [2:NS-2];
    logic signed [W-1:0] r_sx   [2:NS-2];
    logic signed [W-1:0] r_sy   [2:NS-2];
    logic signed [W-1:0] r_ex   [2:NS-2];
    logic signed [W-1:0] r_ey   [2:NS-2];

    logic [2*W:0] w_remx [2:NS-2];
    logic [2*W:0] w_remy [2:NS-2];
    logic [W-1:0] w_quox [2:NS-2];
    logic [W-1:0] w_quoy [2:NS-2];

    logic [W:0]            w_qx, w_qy;
    logic signed [W+1:0]   w_offx, w_offy;
    logic signed [W-1:0]   w_satx, w_saty;
    logic signed [W-1:0]   n_nx, n_ny;
    logic signed [W-1:0]   r_nx, r_ny;

    // Stall control: a stage loads when the receiver is ready or when it or any stage after it is empty.
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_go
            assign w_go[k] = i_m_axis_tready || !(&r_v[NS-1:k]);
        end
    endgenerate

    assign o_s_axis_tready = w_go[0];
    assign o_m_axis_tvalid = r_v[NS-1];
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer      = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_go[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_go[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign w_sx = i_s_axis_tdata[0*W +: W];
    assign w_sy = i_s_axis_tdata[1*W +: W];
    assign w_ex = i_s_axis_tdata[2*W +: W];
    assign w_ey = i_s_axis_tdata[3*W +: W];
    assign w_px = i_s_axis_tdata[4*W +: W];
    assign w_py = i_s_axis_tdata[5*W +: W];

    // Differences against start
    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r0_sx <= w_sx;
            r0_sy <= w_sy;
            r0_ex <= w_ex;
            r0_ey <= w_ey;
            r0_dx <= (W+1)'(w_ex) - (W+1)'(w_sx);
            r0_dy <= (W+1)'(w_ey) - (W+1)'(w_sy);
            r0_qx <= (W+1)'(w_px) - (W+1)'(w_sx);
            r0_qy <= (W+1)'(w_py) - (W+1)'(w_sy);
        end
    end

    // Products
    always_ff @(posedge i_clk) begin
        if (w_go[1]) begin
            r1_sx  <= r0_sx;
            r1_sy  <= r0_sy;
            r1_ex  <= r0_ex;
            r1_ey  <= r0_ey;
            r1_dx  <= r0_dx;
            r1_dy  <= r0_dy;
            r1_pxx <= (2*W+2)'(r0_dx) * (2*W+2)'(r0_qx);
            r1_pyy <= (2*W+2)'(r0_dy) * (2*W+2)'(r0_qy);
            r1_lxx <= (2*W+2)'(r0_dx) * (2*W+2)'(r0_dx);
            r1_lyy <= (2*W+2)'(r0_dy) * (2*W+2)'(r0_dy);
        end
    end

    // Sums and region decision
    always_comb begin
        w_dot = (2*W+3)'(r1_pxx) + (2*W+3)'(r1_pyy);
        w_len = (2*W+3)'(r1_lxx) + (2*W+3)'(r1_lyy);
        if (w_len == '0 || w_dot[2*W+2]) begin
            w_mode = MODE_START;
        end else if (w_dot > w_len) begin
            w_mode = MODE_END;
        end else begin
            w_mode = MODE_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go[2]) begin
            r_mode[2] <= w_mode;
            r_dot[2]  <= w_dot[2*W:0];
            r_len2[2] <= w_len[2*W:0];
            r_magx[2] <= r1_dx[W] ? W'(-r1_dx) : r1_dx[W-1:0];
            r_magy[2] <= r1_dy[W] ? W'(-r1_dy) : r1_dy[W-1:0];
            r_negx[2] <= r1_dx[W];
            r_negy[2] <= r1_dy[W];
            r_sx[2]   <= r1_sx;
            r_sy[2]   <= r1_sy;
            r_ex[2]   <= r1_ex;
            r_ey[2]   <= r1_ey;
        end
    end

    assign w_remx[2] = '0;
    assign w_remy[2] = '0;
    assign w_quox[2] = '0;
    assign w_quoy[2] = '0;

    // Fused multiply-divide: one bit of |d| per stage, MSB first
    generate
        for (k = DS; k <= NS-2; k++) begin : g_div
            always_ff @(posedge i_clk) begin
                if (w_go[k]) begin
                    r_mode[k] <= r_mode[k-1];
                    r_dot[k]  <= r_dot[k-1];
                    r_len2[k] <= r_len2[k-1];
                    r_magx[k] <= r_magx[k-1];
                    r_magy[k] <= r_magy[k-1];
                    r_negx[k] <= r_negx[k-1];
                    r_negy[k] <= r_negy[k-1];
                    r_sx[k]   <= r_sx[k-1];
                    r_sy[k]   <= r_sy[k-1];
                    r_ex[k]   <= r_ex[k-1];
                    r_ey[k]   <= r_ey[k-1];
                end
            end

            cps_mdiv_step #(
                .W (W)
            ) u_step_x (
                .i_clk  (i_clk),
                .i_en   (w_go[k]),
                .i_bit  (r_magx[k-1][NS-2-k]),
                .i_dot  (r_dot[k-1]),
                .i_len2 (r_len2[k-1]),
                .i_rem  (w_remx[k-1]),
                .i_quo  (w_quox[k-1]),
                .o_rem  (w_remx[k]),
                .o_quo  (w_quox[k])
            );

            cps_mdiv_step #(
                .W (W)
            ) u_step_y (
                .i_clk  (i_clk),
                .i_en   (w_go[k]),
                .i_bit  (r_magy[k-1][NS-2-k]),
                .i_dot  (r_dot[k-1]),
                .i_len2 (r_len2[k-1]),
                .i_rem  (w_remy[k-1]),
                .i_quo  (w_quoy[k-1]),
                .o_rem  (w_remy[k]),
                .o_quo  (w_quoy[k])
            );
        end
    endgenerate

    // Round to nearest, offset from start, saturate, select
    always_comb begin
        w_qx = (W+1)'(w_quox[NS-2])
             + (W+1)'(({w_remx[NS-2], 1'b0} >= (2*W+2)'(r_len2[NS-2])) ? 1'b1 : 1'b0);
        w_qy = (W+1)'(w_quoy[NS-2])
             + (W+1)'(({w_remy[NS-2], 1'b0} >= (2*W+2)'(r_len2[NS-2])) ? 1'b1 : 1'b0);

        if (r_negx[NS-2]) begin
            w_offx = (W+2)'(r_sx[NS-2]) - $signed({1'b0, w_qx});
        end else begin
            w_offx = (W+2)'(r_sx[NS-2]) + $signed({1'b0, w_qx});
        end
        if (r_negy[NS-2]) begin
            w_offy = (W+2)'(r_sy[NS-2]) - $signed({1'b0, w_qy});
        end else begin
            w_offy = (W+2)'(r_sy[NS-2]) + $signed({1'b0, w_qy});
        end

        if (w_offx > SAT_HI) begin
            w_satx = SAT_HI[W-1:0];
        end else if (w_offx < SAT_LO) begin
            w_satx = SAT_LO[W-1:0];
        end else begin
            w_satx = w_offx[W-1:0];
        end
        if (w_offy > SAT_HI) begin
            w_saty = SAT_HI[W-1:0];
        end else if (w_offy < SAT_LO) begin
            w_saty = SAT_LO[W-1:0];
        end else begin
            w_saty = w_offy[W-1:0];
        end

        case (r_mode[NS-2])
            MODE_START: begin
                n_nx = r_sx[NS-2];
                n_ny = r_sy[NS-2];
            end
            MODE_END: begin
                n_nx = r_ex[NS-2];
                n_ny = r_ey[NS-2];
            end
            MODE_MID: begin
                n_nx = w_satx;
                n_ny = w_saty;
            end
            default: begin
                n_nx = r_sx[NS-2];
                n_ny = r_sy[NS-2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go[NS-1]) begin
            r_nx <= n_nx;
            r_ny <= n_ny;
        end
    end

    assign o_m_axis_tdata = OUT_W'({r_ny, r_nx});

    assign w_grow    = w_in_xfer && !w_out_xfer;
    assign w_fill    = $countones(r_v);
    assign w_div_mid = r_v[DS] && (r_mode[DS] == MODE_MID);
    assign w_out_mid = r_v[NS-2] && (r_mode[NS-2] == MODE_MID);
    assign w_quo_ok  = (w_qx <= (W+1)'(r_magx[NS-2])) && (w_qy <= (W+1)'(r_magy[NS-2]));

    `CPS_ASSERT(a_ready_when_out_empty, i_clk, i_rst_n, !r_v[NS-1] |-> o_s_axis_tready)
    `CPS_ASSERT(a_mid_has_length, i_clk, i_rst_n, w_div_mid |-> (r_len2[DS] != '0))
    `CPS_ASSERT(a_quo_within_span, i_clk, i_rst_n, w_out_mid |-> w_quo_ok)
    `CPS_ASSERT(a_occupancy_grows, i_clk, i_rst_n, w_grow |=> (w_fill == $past(w_fill) + 1))

endmodule

[tb/tb_closest_point_on_segment.sv]
module tb_closest_point_on_segment;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = cps_pkg::COORD_WIDTH_DEF;
    localparam int IN_BITS   = ((6*CW+7)/8)*8;
    localparam int OUT_BITS  = ((2*CW+7)/8)*8;
    localparam int LATENCY   = CW + 3;
    localparam int HOLD_LEN  = 200;
    localparam int IDLE_LIMIT = 2000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord probe_y;
        t_coord probe_x;
        t_coord end_y;
        t_coord end_x;
        t_coord start_y;
        t_coord start_x;
    } t_query;

    typedef struct packed {
        t_coord nearest_y;
        t_coord nearest_x;
    } t_point;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // start_x, start_y, end_x, end_y, probe_x, probe_y
    logic [IN_BITS-1:0]  i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b1;
    // nearest_x, nearest_y
    logic [OUT_BITS-1:0] o_m_axis_tdata;

    t_point expected_points[$];
    int     errors = 0;
    bit     tx_gaps = 1'b0;
    bit     rx_gaps = 1'b0;
    bit     hold_token = 1'b0;
    bit     hold_seen = 1'b0;
    int     stall_left = 0;
    int     gap_left = 0;
    int     idle_cycles = 0;
    t_point got_point;
    t_point want_point;

    closest_point_on_segment #(.COORD_WIDTH(CW)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_coord clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (CW-1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return t_coord'(v);
    endfunction

    function automatic longint along_axis(longint s, longint d, longint dot, longint len2);
        longint m;
        longint q;
        m = (d < 0) ? -d : d;
        q = (2*m*dot + len2) / (2*len2);
        return (d < 0) ? s - q : s + q;
    endfunction

    function automatic t_point nearest_point(t_query q);
        longint sx, sy, ex, ey, dx, dy, dot, len2;
        t_point r;
        sx = q.start_x;
        sy = q.start_y;
        ex = q.end_x;
        ey = q.end_y;
        dx = ex - sx;
        dy = ey - sy;
        dot = dx*(longint'(q.probe_x) - sx) + dy*(longint'(q.probe_y) - sy);
        len2 = dx*dx + dy*dy;
        if (len2 == 0 || dot < 0) begin
            r.nearest_x = clamp_coord(sx);
            r.nearest_y = clamp_coord(sy);
        end else if (dot > len2) begin
            r.nearest_x = clamp_coord(ex);
            r.nearest_y = clamp_coord(ey);
        end else begin
            r.nearest_x = clamp_coord(along_axis(sx, dx, dot, len2));
            r.nearest_y = clamp_coord(along_axis(sy, dy, dot, len2));
        end
        return r;
    endfunction

    function automatic t_query mk(int sx, int sy, int ex, int ey, int px, int py);
        t_query q;
        q.start_x = t_coord'(sx);
        q.start_y = t_coord'(sy);
        q.end_x   = t_coord'(ex);
        q.end_y   = t_coord'(ey);
        q.probe_x = t_coord'(px);
        q.probe_y = t_coord'(py);
        return q;
    endfunction

    function automatic t_query random_query();
        t_query q;
        int kind;
        int bx, by;
        kind = $urandom_range(0, 9);
        q = t_query'({$urandom, $urandom, $urandom});
        bx = int'($urandom_range(0, 60000)) - 30000;
        by = int'($urandom_range(0, 60000)) - 30000;
        if (kind >= 4 && kind <= 7) begin
            // local geometry: probe often lands between the ends
            q.start_x = t_coord'(bx + int'($urandom_range(0, 512)) - 256);
            q.start_y = t_coord'(by + int'($urandom_range(0, 512)) - 256);
            q.end_x   = t_coord'(bx + int'($urandom_range(0, 512)) - 256);
            q.end_y   = t_coord'(by + int'($urandom_range(0, 512)) - 256);
            q.probe_x = t_coord'(bx + int'($urandom_range(0, 600)) - 300);
            q.probe_y = t_coord'(by + int'($urandom_range(0, 600)) - 300);
        end else if (kind == 8) begin
            q.end_x = q.start_x;
            q.end_y = q.start_y;
        end else if (kind == 9) begin
            if ($urandom_range(0, 1) == 0) q.end_y = q.start_y;
            else q.end_x = q.start_x;
        end
        return q;
    endfunction

    task automatic send_item(t_query q);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= q;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_points.push_back(nearest_point(q));
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results();
        stop_sending();
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        send_item(mk(32767, 32767, 32767, 32767, 32767, 32767));
        send_item(mk(-32768, -32768, 32767, 32767, 0, 0));
        send_item(mk(-32768, -32768, 32767, 32767, 32767, -32768));
        send_item(mk(32767, -32768, -32768, 32767, -32768, -32768));
        send_item(mk(-32768, 0, 32767, 0, 0, 32767));
        send_item(mk(0, -32768, 0, 32767, -32768, -1));
        // zero-length segment
        send_item(mk(100, -200, 100, -200, 5000, 5000));
        // probe behind start, past end, on start, on end
        send_item(mk(0, 0, 100, 0, -50, 30));
        send_item(mk(0, 0, 100, 0, 150, -30));
        send_item(mk(0, 0, 100, 0, 0, 77));
        send_item(mk(0, 0, 100, 0, 100, 99));
        // halfway ties in both directions
        send_item(mk(0, 0, 1, 1, 1, 0));
        send_item(mk(0, 0, -1, -1, -1, 0));
        send_item(mk(10, 10, 13, 10, 11, 5));
        send_item(mk(0, 0, 3, 0, 1, 4));
        send_item(mk(0, 0, 3, 0, 2, -4));
        send_item(mk(5, 300, 5, -300, -1000, 0));
        send_item(mk(-7, 3, 9, -11, 32767, 32767));
        send_item(mk(32767, 32767, -32768, -32768, -32768, 32767));
        wait_results();
    endtask

    task automatic test_random(int n);
        repeat (n) send_item(random_query());
        stop_sending();
    endtask

    task automatic test_backpressure();
        wait_results();
        tx_gaps = 1'b0;
        hold_token <= ~hold_token;
        repeat (80) send_item(random_query());
        tx_gaps = 1'b1;
        wait_results();
    endtask

    task automatic test_sender_pause();
        test_random(150);
        wait_results();
        test_random(150);
    endtask

    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            stall_left = HOLD_LEN;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (gap_left != 0) begin
            gap_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 2);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_point = o_m_axis_tdata;
            if (expected_points.size() == 0) begin
                $display("%0t: result with nothing expected: x=%0d y=%0d",
                         $realtime, got_point.nearest_x, got_point.nearest_y);
                errors++;
            end else begin
                want_point = expected_points.pop_front();
                if (got_point.nearest_x !== want_point.nearest_x) begin
                    $display("%0t: nearest_x expected %0d actual %0d",
                             $realtime, want_point.nearest_x, got_point.nearest_x);
                    errors++;
                end
                if (got_point.nearest_y !== want_point.nearest_y) begin
                    $display("%0t: nearest_y expected %0d actual %0d",
                             $realtime, want_point.nearest_y, got_point.nearest_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout", $realtime);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();

        tx_gaps = 1'b1;
        rx_gaps <= 1'b1;
        test_random(420);
        test_backpressure();
        test_sender_pause();

        // final stretch at full rate
        wait_results();
        tx_gaps = 1'b0;
        rx_gaps <= 1'b0;
        test_random(120);

        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (2*LATENCY) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, expected_points.size());
            errors++;
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
